// ===== hw/rtl/iahc_pkg.sv =====
// Shared types, widths and constants for the intensity-alpha HSL colourise unit.
`timescale 1ns / 1ps
`default_nettype none

package iahc_pkg;

    // Fixed-point format: value 1.0 is ONE
    localparam int FRAC_BITS = 16;
    localparam int LW        = FRAC_BITS + 1;   // lightness, p, sp, 1 - p
    localparam int MW        = FRAC_BITS + 2;   // m1, m2, span, segment value
    localparam int FW        = 6;               // segment fraction in degrees, 0..60
    localparam int XW        = MW + FW;         // span * fraction
    localparam int RK        = XW + 6;          // shift of the 1/60 reciprocal
    localparam int RW        = RK - 5;          // width of the 1/60 reciprocal
    localparam int QW        = XW - 5;          // quotient by 60
    localparam int CW        = MW + 8 - FRAC_BITS; // colour before clamping
    localparam int NCH       = 3;

    localparam logic [LW-1:0] ONE     = LW'(64'd1 << FRAC_BITS);
    localparam logic [LW-1:0] HALF    = LW'(64'd1 << (FRAC_BITS - 1));
    localparam logic [RW-1:0] RECIP60 = RW'((64'd1 << RK) / 64'd60);

    localparam logic [FW-1:0] SEG_SPAN    = FW'(60);
    localparam logic [7:0]    ALPHA_LIMIT = 8'd250;
    localparam logic [7:0]    BYTE_MAX    = 8'hFF;

    // Colour channel order inside the channel arrays
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Configuration register indexes
    localparam int CFG_DW = 9;
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HUE   = 2'd0;
    localparam t_cfg_idx CFG_SAT   = 2'd1;
    localparam t_cfg_idx CFG_LIGHT = 2'd2;

    // Hue segment of one channel
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    typedef struct packed {
        t_seg          cls;
        logic [FW-1:0] f;
    } t_chan;

    // Values derived from the configuration registers
    typedef struct packed {
        logic [LW-1:0]        omp;   // one minus lightness step
        logic [LW-1:0]        padd;  // lightness step added toward white
        logic [LW-1:0]        sp;    // saturation as a fraction
        t_chan [NCH-1:0]      chan;
    } t_cfg_drv;

    typedef struct packed {
        logic [7:0] intensity;
        logic [7:0] alpha_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] alpha_out;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_out;

    // Fields that ride along the pipeline unchanged
    typedef struct packed {
        logic [7:0] inten;
        logic [7:0] alpha;
        logic       grey;
    } t_side;

    typedef struct packed {
        t_side         side;
        logic [MW-1:0] m1;
        logic [MW-1:0] m2;
    } t_mix;

endpackage

`default_nettype wire

// ===== hw/rtl/iahc_cfg.sv =====
// Configuration registers and the per-image values derived from them.
`timescale 1ns / 1ps
`default_nettype none

module iahc_cfg import iahc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    output t_cfg_drv               o_drv
);

    localparam logic [8:0]         HUE_MAX   = 9'd360;
    localparam logic [6:0]         SAT_MAX   = 7'd100;
    localparam logic signed [7:0]  LIGHT_MAX = 8'sd100;
    localparam logic signed [10:0] DEG_0     = 11'sd0;
    localparam logic signed [10:0] DEG_60    = 11'sd60;
    localparam logic signed [10:0] DEG_120   = 11'sd120;
    localparam logic signed [10:0] DEG_180   = 11'sd180;
    localparam logic signed [10:0] DEG_240   = 11'sd240;
    localparam logic signed [10:0] DEG_360   = 11'sd360;

    logic [8:0]        r_hue;
    logic [6:0]        r_sat;
    logic signed [7:0] r_light;
    t_cfg_drv          r_drv;

    logic [8:0]        w_hue;
    logic [6:0]        w_sat;
    logic signed [7:0] w_light;
    logic [6:0]        w_mag;
    logic [LW-1:0]     w_p;
    t_cfg_drv          w_drv;
    logic [LW-1:0]     w_pct_tab [101];

    // Percent to fraction table: floor(i * ONE / 100)
    for (genvar gi = 0; gi <= 100; gi++) begin : g_pct
        assign w_pct_tab[gi] = LW'((64'(gi) << FRAC_BITS) / 64'd100);
    end

    // Segment and fraction for one channel's hue angle
    function automatic t_chan chan_of(input logic [8:0] hue, input logic signed [10:0] ofs);
        logic signed [10:0] d;
        t_chan              c;
        d = $signed({2'b00, hue}) + ofs;
        if (d > DEG_360) begin
            d = d - DEG_360;
        end else if (d < DEG_0) begin
            d = d + DEG_360;
        end
        priority if (d < DEG_60) begin
            c.cls = SEG_RISE;
            c.f   = FW'(d);
        end else if (d < DEG_180) begin
            c.cls = SEG_HIGH;
            c.f   = '0;
        end else if (d < DEG_240) begin
            c.cls = SEG_FALL;
            c.f   = FW'(DEG_240 - d);
        end else begin
            c.cls = SEG_LOW;
            c.f   = '0;
        end
        return c;
    endfunction

    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue   <= '0;
            r_sat   <= '0;
            r_light <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HUE:   r_hue   <= i_cfg_data[8:0];
                CFG_SAT:   r_sat   <= i_cfg_data[6:0];
                CFG_LIGHT: r_light <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Clamp the settings and derive the fixed-point factors
    always_comb begin
        w_hue = (r_hue > HUE_MAX) ? HUE_MAX : r_hue;
        w_sat = (r_sat > SAT_MAX) ? SAT_MAX : r_sat;
        if (r_light > LIGHT_MAX) begin
            w_light = LIGHT_MAX;
        end else if (r_light < -LIGHT_MAX) begin
            w_light = -LIGHT_MAX;
        end else begin
            w_light = r_light;
        end
        w_mag = w_light[7] ? 7'(-w_light) : w_light[6:0];
        w_p   = w_pct_tab[w_mag];

        w_drv.omp  = ONE - w_p;
        w_drv.padd = (!w_light[7] && (w_light != 8'sd0)) ? w_p : '0;
        w_drv.sp   = w_pct_tab[w_sat];
        w_drv.chan[CH_RED]   = chan_of(w_hue, DEG_120);
        w_drv.chan[CH_GREEN] = chan_of(w_hue, DEG_0);
        w_drv.chan[CH_BLUE]  = chan_of(w_hue, -DEG_120);
    end

    always_ff @(posedge i_clk) begin
        r_drv <= w_drv;
    end

    assign o_drv = r_drv;

endmodule

`default_nettype wire

// ===== hw/rtl/iahc_lum.sv =====
// Front pipeline: lightness lookup, lightness shift, and the m1/m2 HSL terms.
`timescale 1ns / 1ps
`default_nettype none

module iahc_lum import iahc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_pix_in  i_in_pix,
    input  wire t_cfg_drv i_drv,
    output logic          o_mix_valid,
    output t_mix          o_mix,
    input  wire logic     i_down_en
);

    localparam int NST = 7;

    logic [NST:1]     r_vld;
    logic [NST+1:1]   w_en;
    t_side            r_side [1:NST];

    logic [LW-1:0]    r_lum0;
    logic [2*LW-1:0]  r_prod3;
    logic [LW-1:0]    r_lum4;
    logic [2*LW-1:0]  r_prod5;
    logic [LW-1:0]    r_lum5;
    logic [MW-1:0]    r_m2_6;
    logic [LW-1:0]    r_lum6;
    logic [MW-1:0]    r_m1_7;
    logic [MW-1:0]    r_m2_7;

    logic [LW-1:0]    w_lum_tab [256];
    logic [LW-1:0]    w_lum4;
    logic [LW-1:0]    w_prod5_sh;
    logic [MW-1:0]    w_m2;
    logic [MW-1:0]    w_two;
    logic [MW-1:0]    w_m1;
    logic [MW-1:0]    w_m2c;

    // Intensity to lightness table: floor(i * ONE / 255)
    for (genvar gi = 0; gi < 256; gi++) begin : g_lum
        assign w_lum_tab[gi] = LW'((64'(gi) << FRAC_BITS) / 64'd255);
    end

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NST+1] = i_down_en;
        for (int k = NST; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Datapath between stages
    always_comb begin
        w_lum4     = r_prod3[FRAC_BITS +: LW] + i_drv.padd;
        w_prod5_sh = r_prod5[FRAC_BITS +: LW];
        if (r_lum5 <= HALF) begin
            w_m2 = MW'(r_lum5) + MW'(w_prod5_sh);
        end else begin
            w_m2 = MW'(r_lum5) + MW'(i_drv.sp) - MW'(w_prod5_sh);
        end
        w_two = {r_lum6, 1'b0};
        w_m1  = (w_two > r_m2_6) ? (w_two - r_m2_6) : '0;
        w_m2c = (r_m2_6 < w_m1) ? w_m1 : r_m2_6;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_side[1] <= '{inten: i_in_pix.intensity,
                           alpha: i_in_pix.alpha_in,
                           grey:  (i_in_pix.alpha_in < ALPHA_LIMIT)};
        end
        for (int k = 2; k <= NST; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_en[2]) begin
            r_lum0 <= w_lum_tab[r_side[1].inten];
        end
        if (w_en[3]) begin
            r_prod3 <= (2*LW)'(r_lum0) * (2*LW)'(i_drv.omp);
        end
        if (w_en[4]) begin
            r_lum4 <= w_lum4;
        end
        if (w_en[5]) begin
            r_prod5 <= (2*LW)'(r_lum4) * (2*LW)'(i_drv.sp);
            r_lum5  <= r_lum4;
        end
        if (w_en[6]) begin
            r_m2_6 <= w_m2;
            r_lum6 <= r_lum5;
        end
        if (w_en[7]) begin
            r_m1_7 <= w_m1;
            r_m2_7 <= w_m2c;
        end
    end

    assign o_in_stall  = !w_en[1];
    assign o_mix_valid = r_vld[NST];
    assign o_mix       = '{side: r_side[NST], m1: r_m1_7, m2: r_m2_7};

    a_lum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r_lum4 <= ONE))
        else $error("shifted lightness above one");

    a_mix_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NST] |-> (r_m1_7 <= r_m2_7))
        else $error("m1 above m2");

    a_mix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NST] && !i_down_en) |=> (r_vld[NST] && $stable(r_m2_7) && $stable(r_m1_7)))
        else $error("stalled item lost at front pipeline exit");

endmodule

`default_nettype wire

// ===== hw/rtl/iahc_seg.sv =====
// Back pipeline: hue segment interpolation, division by 60 and byte conversion.
`timescale 1ns / 1ps
`default_nettype none

module iahc_seg import iahc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_mix_valid,
    input  wire t_mix     i_mix,
    output logic          o_up_en,
    input  wire t_cfg_drv i_drv,
    output logic          o_out_valid,
    output t_pix_out      o_out_pix,
    input  wire logic     i_out_stall
);

    logic [11:8]          r_vld;
    logic [12:8]          w_en;
    t_side                r_side [8:10];
    logic [MW-1:0]        r_m1 [8:9];
    logic [MW-1:0]        r_m2 [8:9];
    logic [XW-1:0]        r_x8 [NCH];
    logic [XW-1:0]        r_x9 [NCH];
    logic [XW+RW-1:0]     r_y9 [NCH];
    logic [MW-1:0]        r_val10 [NCH];
    t_pix_out             r_out;

    logic [MW-1:0]        w_span;
    logic [XW-1:0]        w_x [NCH];
    logic [QW-1:0]        w_q [NCH];
    logic [XW:0]          w_q60 [NCH];
    logic [XW-1:0]        w_rem [NCH];
    logic [QW-1:0]        w_qa [NCH];
    logic [MW-1:0]        w_val [NCH];
    logic [MW+7:0]        w_bw [NCH];
    logic [CW-1:0]        w_c [NCH];
    logic [7:0]           w_byte [NCH];

    // Stage enables
    always_comb begin
        w_en[12] = !i_out_stall;
        for (int k = 11; k >= 8; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Per channel: span * fraction, quotient by 60 with one correction, byte
    always_comb begin
        w_span = i_mix.m2 - i_mix.m1;
        for (int c = 0; c < NCH; c++) begin
            w_x[c]   = XW'(w_span) * XW'(i_drv.chan[c].f);
            w_q[c]   = r_y9[c][RK +: QW];
            w_q60[c] = (XW+1)'({w_q[c], 6'b0}) - (XW+1)'({w_q[c], 2'b0});
            w_rem[c] = r_x9[c] - w_q60[c][XW-1:0];
            w_qa[c]  = w_q[c] + QW'(w_rem[c] >= XW'(SEG_SPAN));
            unique case (i_drv.chan[c].cls)
                SEG_RISE, SEG_FALL: w_val[c] = r_m1[9] + w_qa[c][MW-1:0];
                SEG_HIGH:           w_val[c] = r_m2[9];
                SEG_LOW:            w_val[c] = r_m1[9];
                default:            w_val[c] = r_m1[9];
            endcase
            w_bw[c]   = {r_val10[c], 8'b0} - (MW+8)'(r_val10[c]);
            w_c[c]    = w_bw[c][FRAC_BITS +: CW];
            w_byte[c] = (w_c[c] > CW'(BYTE_MAX)) ? BYTE_MAX : w_c[c][7:0];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[8]) begin
                r_vld[8] <= i_mix_valid;
            end
            for (int k = 9; k <= 11; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_side[8] <= i_mix.side;
            r_m1[8]   <= i_mix.m1;
            r_m2[8]   <= i_mix.m2;
            for (int c = 0; c < NCH; c++) begin
                r_x8[c] <= w_x[c];
            end
        end
        if (w_en[9]) begin
            r_side[9] <= r_side[8];
            r_m1[9]   <= r_m1[8];
            r_m2[9]   <= r_m2[8];
            for (int c = 0; c < NCH; c++) begin
                r_x9[c] <= r_x8[c];
                r_y9[c] <= (XW+RW)'(r_x8[c]) * (XW+RW)'(RECIP60);
            end
        end
        if (w_en[10]) begin
            r_side[10] <= r_side[9];
            for (int c = 0; c < NCH; c++) begin
                r_val10[c] <= w_val[c];
            end
        end
        if (w_en[11]) begin
            r_out.alpha_out <= r_side[10].alpha;
            r_out.red   <= r_side[10].grey ? r_side[10].inten : w_byte[CH_RED];
            r_out.green <= r_side[10].grey ? r_side[10].inten : w_byte[CH_GREEN];
            r_out.blue  <= r_side[10].grey ? r_side[10].inten : w_byte[CH_BLUE];
        end
    end

    assign o_up_en     = w_en[8];
    assign o_out_valid = r_vld[11];
    assign o_out_pix   = r_out;

    // The reciprocal estimate may only fall one short of the true quotient
    for (genvar gc = 0; gc < NCH; gc++) begin : g_chk
        a_quot_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[9] |-> (w_rem[gc] < (XW'(SEG_SPAN) << 1)))
            else $error("divide by 60 estimate off by more than one");
    end

endmodule

`default_nettype wire

// ===== hw/rtl/intensity_alpha_hsl_colourise_unit.sv =====
// Top level of the intensity-alpha HSL colourise unit.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_in_pix  (intensity, alpha_in)
//  out     | source    | o_out_valid / i_out_stall | o_out_pix (alpha_out, r, g, b)
//  cfg     | sink      | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_stall is low; o_out_valid rises once
// the item has passed through the 11-stage datapath: two multiplies for lightness
// and saturation, one for span * fraction and one for the reciprocal of 60.
// Reset (synchronous, active low) clears all valid bits and the configuration registers.
// A stall on the output fills empty stages first; the input stalls only
// when every stage holds an item.
`timescale 1ns / 1ps
`default_nettype none

module intensity_alpha_hsl_colourise_unit import iahc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire t_pix_in           i_in_pix,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_pix_out               o_out_pix,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    t_cfg_drv w_drv;
    logic     w_mix_valid;
    t_mix     w_mix;
    logic     w_down_en;

    // Settings and derived factors
    iahc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_drv       (w_drv)
    );

    // Lightness and m1/m2
    iahc_lum u_lum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_pix    (i_in_pix),
        .i_drv       (w_drv),
        .o_mix_valid (w_mix_valid),
        .o_mix       (w_mix),
        .i_down_en   (w_down_en)
    );

    // Hue segments and colour bytes
    iahc_seg u_seg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mix_valid (w_mix_valid),
        .i_mix       (w_mix),
        .o_up_en     (w_down_en),
        .i_drv       (w_drv),
        .o_out_valid (o_out_valid),
        .o_out_pix   (o_out_pix),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
